### src/ptq_pkg.sv
package ptq_pkg;

  localparam int PTQ_MAX_VERTICES = 1024;
  localparam int COORD_W = 24;
  localparam int SLOPE_W = 32;
  localparam int UNIT_W = 16;
  localparam int INDEX_W = 10;
  localparam int COUNT_W = 11;
  localparam int CFG_ADDR_W = 8;
  localparam int DIV_NW = 50;
  localparam int DIV_DW = 26;
  localparam logic [14:0] ONE_Q14 = 15'd16384;

  localparam logic [CFG_ADDR_W-1:0] REG_ENABLED = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_VERTEX_COUNT = 8'd1;

  localparam logic MODE_LOAD = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SRCH, ST_SRCH_W, ST_RDA, ST_RDB, ST_RDW, ST_MUL, ST_HGO,
    ST_DIV_H, ST_DIV_S, ST_NORM, ST_L2A, ST_L2B, ST_UK, ST_UP, ST_UC
  } ptq_state_t;

endpackage

### src/ptq_if.sv
interface ptq_in_if import ptq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [INDEX_W-1:0]         vertex_index;
  logic signed [COORD_W-1:0]  vertex_x;
  logic signed [COORD_W-1:0]  vertex_y;
  logic signed [COORD_W-1:0]  query_x;
  modport source (output valid, mode, vertex_index, vertex_x, vertex_y, query_x, input ready);
  modport sink (input valid, mode, vertex_index, vertex_x, vertex_y, query_x, output ready);
endinterface

interface ptq_out_if import ptq_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  height;
  logic signed [SLOPE_W-1:0]  slope;
  logic signed [UNIT_W-1:0]   tangent_x;
  logic signed [UNIT_W-1:0]   tangent_y;
  logic signed [UNIT_W-1:0]   normal_x;
  logic signed [UNIT_W-1:0]   normal_y;
  modport source (output valid, height, slope, tangent_x, tangent_y, normal_x, normal_y,
                  input ready);
  modport sink (input valid, height, slope, tangent_x, tangent_y, normal_x, normal_y,
                output ready);
endinterface

interface ptq_cfg_if import ptq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_ADDR_W-1:0]  index;
  logic [COUNT_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/ptq_div.sv
module ptq_div import ptq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quo
);

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic [CNT_W-1:0]  cnt_r;
  logic              done_r;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW:0]   rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW:0]   diff;
  logic              ge;

  always_comb begin
    rem_sh = {rem_r[DIV_DW-1:0], quo_r[DIV_NW-1]};
    diff = rem_sh - {1'b0, den_r};
    ge = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(DIV_NW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? diff : rem_sh;
      quo_r <= {quo_r[DIV_NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo = quo_r;

endmodule

### src/piecewise_linear_terrain_query_unit.sv
// Load transactions produce no result.
// Query transactions run a binary search over the vertex x table, up to two divisions in the
// shared divider and up to 15 binary search steps per tangent component.
// One query is in flight at a time; a finished result waits in the output register.
// Reset (synchronous, active low) clears the state, config registers and output valid; the tables are unset.
module piecewise_linear_terrain_query_unit import ptq_pkg::*; #(
  parameter int MAX_VERTICES = PTQ_MAX_VERTICES
) (
  input  logic       clk,
  input  logic       rst_n,
  ptq_in_if.sink     in_chan,
  ptq_out_if.source  out_chan,
  ptq_cfg_if.sink    cfg_chan
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  ptq_state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] xmem [MAX_VERTICES];
  logic signed [COORD_W-1:0] ymem [MAX_VERTICES];
  logic signed [COORD_W-1:0] rd_x_r, rd_y_r;
  logic [IW-1:0] rd_addr;

  logic enabled_r;
  logic [COUNT_W-1:0] count_r;
  logic [CW-1:0] n;

  logic signed [COORD_W-1:0] qx_r, ax_r, ay_r;
  logic [CW-1:0] lo_r, hi_r, mid, mid_r;
  logic [IW-1:0] ia_r, ib_r;
  logic signed [COORD_W:0] dx_r, dy_r;
  logic signed [2*COORD_W+1:0] prod_r;
  logic signed [COORD_W-1:0] height_r;
  logic signed [SLOPE_W-1:0] slope_r;

  logic div_start, div_done;
  logic [DIV_NW-1:0] div_num, div_quo;
  logic [DIV_DW-1:0] div_den;
  logic [2*COORD_W+1:0] abs_prod;
  logic [COORD_W:0] abs_dx, abs_dy, m_abs;
  logic signed [DIV_NW+1:0] q_s, sum_h, sum_s;
  logic [3:0] sh;

  logic [15:0] ux_r, uy_r;
  logic [31:0] ux2_r, uy2_r;
  logic [32:0] l2_r;
  logic cb_r;
  logic [14:0] ulo_r, uhi_r, txm_r, umid;
  logic [15:0] usum;
  logic [14:0] kk;
  logic [29:0] k2_r;
  logic [46:0] plo_r;
  logic [45:0] phi_r;
  logic [62:0] ptot, rhs;

  logic in_acc, done_ok;
  logic signed [UNIT_W-1:0] tx_s, ty_s;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign done_ok = !out_chan.valid || out_chan.ready;

  assign n = (32'(count_r) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(count_r);
  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      count_r <= '0;
    end else if (cfg_chan.valid) begin
      if (cfg_chan.index == REG_ENABLED) begin
        enabled_r <= cfg_chan.data[0];
      end else if (cfg_chan.index == REG_VERTEX_COUNT) begin
        count_r <= cfg_chan.data;
      end
    end
  end

  always_comb begin
    case (state_r)
      ST_RDA:  rd_addr = ia_r;
      ST_RDB:  rd_addr = ib_r;
      default: rd_addr = mid[IW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_chan.mode == MODE_LOAD &&
        32'(in_chan.vertex_index) < 32'(MAX_VERTICES)) begin
      xmem[IW'(in_chan.vertex_index)] <= in_chan.vertex_x;
      ymem[IW'(in_chan.vertex_index)] <= in_chan.vertex_y;
    end
    rd_x_r <= xmem[rd_addr];
    rd_y_r <= ymem[rd_addr];
  end

  always_comb begin
    abs_prod = prod_r[2*COORD_W+1] ? 50'(-prod_r) : 50'(prod_r);
    abs_dx = dx_r[COORD_W] ? 25'(-dx_r) : 25'(dx_r);
    abs_dy = dy_r[COORD_W] ? 25'(-dy_r) : 25'(dy_r);
    m_abs = (abs_dx > abs_dy) ? abs_dx : abs_dy;
    sh = '0;
    for (int i = 16; i <= COORD_W; i++) begin
      if (m_abs[i]) begin
        sh = 4'(i - 15);
      end
    end
    div_start = 1'b0;
    div_den = {abs_dx, 1'b0};
    if (state_r == ST_DIV_H) begin
      div_num = DIV_NW'({abs_dy, 17'd0}) + DIV_NW'(abs_dx);
    end else begin
      div_num = DIV_NW'({abs_prod[2*COORD_W-1:0], 1'b0}) + DIV_NW'(abs_dx);
    end
    if (state_r == ST_HGO || (state_r == ST_DIV_H && div_done)) begin
      div_start = 1'b1;
    end
    q_s = $signed({2'b00, div_quo});
    sum_h = $signed(52'(ay_r)) + ((prod_r[2*COORD_W+1] ^ dx_r[COORD_W]) ? -q_s : q_s);
    sum_s = (dy_r[COORD_W] ^ dx_r[COORD_W]) ? -q_s : q_s;
    usum = 16'(uhi_r) - 16'(ulo_r) + 16'd1;
    umid = ulo_r + usum[15:1];
    kk = 15'({umid, 1'b0} - 16'd1);
    ptot = 63'(plo_r) + (63'(phi_r) << 17);
    rhs = 63'(cb_r ? uy2_r : ux2_r) << 30;
    tx_s = dx_r[COORD_W] ? -$signed({1'b0, txm_r}) : $signed({1'b0, txm_r});
    ty_s = dy_r[COORD_W] ? -$signed({1'b0, ulo_r}) : $signed({1'b0, ulo_r});
  end

  ptq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_chan.mode != MODE_LOAD) begin
          state_nxt = (enabled_r && n >= CW'(2)) ? ST_SRCH : ST_UK;
        end
      end
      ST_SRCH:   state_nxt = (lo_r < hi_r) ? ST_SRCH_W : ST_RDA;
      ST_SRCH_W: state_nxt = ST_SRCH;
      ST_RDA:    state_nxt = ST_RDB;
      ST_RDB:    state_nxt = ST_RDW;
      ST_RDW:    state_nxt = ST_MUL;
      ST_MUL:    state_nxt = (dx_r == '0) ? ST_NORM : ST_HGO;
      ST_HGO:    state_nxt = ST_DIV_H;
      ST_DIV_H:  state_nxt = div_done ? ST_DIV_S : ST_DIV_H;
      ST_DIV_S:  state_nxt = div_done ? ST_NORM : ST_DIV_S;
      ST_NORM:   state_nxt = (dx_r == '0 && dy_r == '0) ? ST_UK : ST_L2A;
      ST_L2A:    state_nxt = ST_L2B;
      ST_L2B:    state_nxt = ST_UK;
      ST_UK: begin
        if (ulo_r != uhi_r) begin
          state_nxt = ST_UP;
        end else if (!cb_r) begin
          state_nxt = ST_UK;
        end else if (done_ok) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_UP:     state_nxt = ST_UC;
      ST_UC:     state_nxt = ST_UK;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        qx_r <= in_chan.query_x;
        lo_r <= '0;
        hi_r <= n;
        dx_r <= '0;
        dy_r <= '0;
        height_r <= '0;
        slope_r <= '0;
        cb_r <= 1'b1;
        ulo_r <= '0;
        uhi_r <= '0;
        txm_r <= ONE_Q14;
      end
      ST_SRCH: begin
        mid_r <= mid;
        if (lo_r >= hi_r) begin
          if (lo_r == n) begin
            ia_r <= IW'(n - CW'(2));
            ib_r <= IW'(n - CW'(1));
          end else if (lo_r == '0) begin
            ia_r <= '0;
            ib_r <= IW'(1);
          end else begin
            ia_r <= IW'(lo_r - CW'(1));
            ib_r <= lo_r[IW-1:0];
          end
        end
      end
      ST_SRCH_W: begin
        if (rd_x_r < qx_r) begin
          lo_r <= mid_r + CW'(1);
        end else begin
          hi_r <= mid_r;
        end
      end
      ST_RDB: begin
        ax_r <= rd_x_r;
        ay_r <= rd_y_r;
      end
      ST_RDW: begin
        dx_r <= 25'(rd_x_r) - 25'(ax_r);
        dy_r <= 25'(rd_y_r) - 25'(ay_r);
      end
      ST_MUL: begin
        prod_r <= (25'(qx_r) - 25'(ax_r)) * dy_r;
        height_r <= ay_r;
        slope_r <= '0;
      end
      ST_DIV_H: begin
        if (div_done) begin
          if (sum_h > 52'sd8388607) begin
            height_r <= 24'sh7FFFFF;
          end else if (sum_h < -52'sd8388608) begin
            height_r <= 24'sh800000;
          end else begin
            height_r <= sum_h[COORD_W-1:0];
          end
        end
      end
      ST_DIV_S: begin
        if (div_done) begin
          if (sum_s > 52'sd2147483647) begin
            slope_r <= 32'sh7FFFFFFF;
          end else if (sum_s < -52'sd2147483648) begin
            slope_r <= 32'sh80000000;
          end else begin
            slope_r <= sum_s[SLOPE_W-1:0];
          end
        end
      end
      ST_NORM: begin
        ux_r <= 16'(abs_dx >> sh);
        uy_r <= 16'(abs_dy >> sh);
      end
      ST_L2A: begin
        ux2_r <= ux_r * ux_r;
        uy2_r <= uy_r * uy_r;
      end
      ST_L2B: begin
        l2_r <= 33'(ux2_r) + 33'(uy2_r);
        cb_r <= 1'b0;
        ulo_r <= '0;
        uhi_r <= ONE_Q14;
      end
      ST_UK: begin
        k2_r <= kk * kk;
        if (ulo_r == uhi_r && !cb_r) begin
          txm_r <= ulo_r;
          cb_r <= 1'b1;
          ulo_r <= '0;
          uhi_r <= ONE_Q14;
        end
      end
      ST_UP: begin
        plo_r <= k2_r * l2_r[16:0];
        phi_r <= k2_r * l2_r[32:17];
      end
      ST_UC: begin
        if (ptot <= rhs) begin
          ulo_r <= umid;
        end else begin
          uhi_r <= umid - 15'd1;
        end
      end
      default: begin
      end
    endcase
  end

  logic out_valid_r;
  logic signed [COORD_W-1:0] out_height_r;
  logic signed [SLOPE_W-1:0] out_slope_r;
  logic signed [UNIT_W-1:0] out_tx_r, out_ty_r;
  logic out_load;

  assign out_load = (state_r == ST_UK) && cb_r && (ulo_r == uhi_r) && done_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_height_r <= height_r;
      out_slope_r <= slope_r;
      out_tx_r <= tx_s;
      out_ty_r <= ty_s;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.height = out_height_r;
  assign out_chan.slope = out_slope_r;
  assign out_chan.tangent_x = out_tx_r;
  assign out_chan.tangent_y = out_ty_r;
  assign out_chan.normal_x = -out_ty_r;
  assign out_chan.normal_y = out_tx_r;

endmodule

### tb/piecewise_linear_terrain_query_unit_tb.sv
module piecewise_linear_terrain_query_unit_tb;
  import ptq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_QUERY = ~MODE_LOAD;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 2000;
  localparam int TARGET_ITEMS = 1200;

  typedef struct packed {
    logic signed [COORD_W-1:0] height;
    logic signed [SLOPE_W-1:0] slope;
    logic signed [UNIT_W-1:0]  tangent_x;
    logic signed [UNIT_W-1:0]  tangent_y;
    logic signed [UNIT_W-1:0]  normal_x;
    logic signed [UNIT_W-1:0]  normal_y;
  } terrain_result_t;

  logic clk;
  logic rst_n;

  ptq_in_if  in_chan ();
  ptq_out_if out_chan ();
  ptq_cfg_if cfg_chan ();

  piecewise_linear_terrain_query_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  int vx_table [PTQ_MAX_VERTICES];
  int vy_table [PTQ_MAX_VERTICES];
  bit terrain_enabled;
  int unsigned terrain_count;

  terrain_result_t pending_results [$];
  terrain_result_t got;
  int failures;
  int items_sent;
  int queries_sent;
  int loads_sent;
  int phases_run;
  int results_seen;
  bit no_idle;
  int hold_seq;
  int hold_seen;
  int hold_left;
  int stall_cycles;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int rnd24();
    logic [23:0] r;
    r = 24'($urandom);
    return int'($signed(r));
  endfunction

  function automatic int clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return int'(v);
  endfunction

  function automatic longint div_nearest(longint num, longint den);
    longint unsigned an, ad, q;
    an = num < 0 ? -num : num;
    ad = den < 0 ? -den : den;
    q = (2 * an + ad) / (2 * ad);
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp_range(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unit_component(longint unsigned c, longint unsigned l2);
    longint unsigned rhs, lo, hi, mid, k;
    rhs = (c * c) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      k = 2 * mid - 1;
      if (k * k * l2 <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return longint'(lo);
  endfunction

  function automatic terrain_result_t terrain_lookup(int qx);
    terrain_result_t r;
    int unsigned n, lo, hi, mid, ia, ib;
    longint ax, ay, dx, dy, hgt, slp, tx, ty;
    longint unsigned ux, uy, m, l2;
    int s;
    n = terrain_count > PTQ_MAX_VERTICES ? PTQ_MAX_VERTICES : terrain_count;
    hgt = 0;
    slp = 0;
    tx = 16384;
    ty = 0;
    if (terrain_enabled && n >= 2) begin
      lo = 0;
      hi = n;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (vx_table[mid] < qx) lo = mid + 1;
        else hi = mid;
      end
      if (lo == n) begin
        ia = n - 2;
        ib = n - 1;
      end else if (lo == 0) begin
        ia = 0;
        ib = 1;
      end else begin
        ia = lo - 1;
        ib = lo;
      end
      ax = vx_table[ia];
      ay = vy_table[ia];
      dx = longint'(vx_table[ib]) - ax;
      dy = longint'(vy_table[ib]) - ay;
      if (dx == 0) begin
        hgt = ay;
      end else begin
        hgt = clamp_range(ay + div_nearest((qx - ax) * dy, dx), -8388608, 8388607);
        slp = clamp_range(div_nearest(dy * 65536, dx), -64'sd2147483648, 64'sd2147483647);
      end
      if (dx != 0 || dy != 0) begin
        ux = dx < 0 ? -dx : dx;
        uy = dy < 0 ? -dy : dy;
        m = ux > uy ? ux : uy;
        s = 0;
        while ((m >> s) >= 65536) s++;
        ux = ux >> s;
        uy = uy >> s;
        l2 = ux * ux + uy * uy;
        tx = unit_component(ux, l2);
        ty = unit_component(uy, l2);
        if (dx < 0) tx = -tx;
        if (dy < 0) ty = -ty;
      end
    end
    r.height = hgt[COORD_W-1:0];
    r.slope = slp[SLOPE_W-1:0];
    r.tangent_x = tx[UNIT_W-1:0];
    r.tangent_y = ty[UNIT_W-1:0];
    r.normal_x = -ty[UNIT_W-1:0];
    r.normal_y = tx[UNIT_W-1:0];
    return r;
  endfunction

  task automatic send_item(logic md, int idx, int vx, int vy, int qx);
    in_chan.valid <= 1'b1;
    in_chan.mode <= md;
    in_chan.vertex_index <= idx[INDEX_W-1:0];
    in_chan.vertex_x <= vx[COORD_W-1:0];
    in_chan.vertex_y <= vy[COORD_W-1:0];
    in_chan.query_x <= qx[COORD_W-1:0];
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
    if (md == MODE_LOAD) begin
      vx_table[idx] = vx;
      vy_table[idx] = vy;
      loads_sent++;
    end else begin
      pending_results = {pending_results, terrain_lookup(qx)};
      queries_sent++;
    end
    if (!no_idle && $urandom_range(99) < 22) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic load_vertex(int idx, int vx, int vy);
    send_item(MODE_LOAD, idx, vx, vy, rnd24());
  endtask

  task automatic query_at(int qx);
    send_item(MODE_QUERY, $urandom_range(1023), rnd24(), rnd24(), qx);
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int value);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= value[COUNT_W-1:0];
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    if (idx == REG_ENABLED) terrain_enabled = value[0];
    else if (idx == REG_VERTEX_COUNT) terrain_count = value[COUNT_W-1:0];
    @(posedge clk);
  endtask

  task automatic test_flat_results();
    query_at(-8388608);
    query_at(8388607);
    wait_drained();
    write_reg(REG_ENABLED, 1);
    query_at(0);
    wait_drained();
    write_reg(REG_VERTEX_COUNT, 1);
    query_at(rnd24());
    wait_drained();
  endtask

  task automatic test_directed_segments();
    load_vertex(0, -8388608, -8388608);
    load_vertex(1, -4096, 0);
    load_vertex(2, 0, 8388607);
    load_vertex(3, 0, -8388608);
    wait_drained();
    write_reg(REG_VERTEX_COUNT, 4);
    query_at(-8388608);
    query_at(-4096);
    query_at(-1);
    query_at(0);
    query_at(8388607);
    wait_drained();
    write_reg(REG_VERTEX_COUNT, 2);
    query_at(8388607);
    load_vertex(0, 0, -8388608);
    load_vertex(1, 1, 8388607);
    query_at(-8388608);
    query_at(8388607);
    load_vertex(1, 0, -8388608);
    query_at(5);
    load_vertex(1, -5, 3);
    query_at(-2);
    wait_drained();
  endtask

  task automatic test_full_table();
    for (int i = 0; i < PTQ_MAX_VERTICES; i++) load_vertex(i, i * 8192 - 8388608, rnd24());
    wait_drained();
    write_reg(REG_VERTEX_COUNT, 2047);
    repeat (6) query_at(rnd24());
    query_at(8388607);
    wait_drained();
    write_reg(REG_VERTEX_COUNT, 1024);
    repeat (6) query_at(rnd24());
    query_at(-8388608);
    wait_drained();
    write_reg(REG_VERTEX_COUNT, 1023);
    query_at(8388607);
    wait_drained();
  endtask

  task automatic random_phase();
    int n;
    int nq;
    int k;
    int xs [$];
    phases_run++;
    wait_drained();
    n = ($urandom_range(19) == 0) ? $urandom_range(17, 200) : $urandom_range(2, 16);
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(7) == 0) xs = {xs, xs[i-1]};
      else xs = {xs, rnd24()};
    end
    if ($urandom_range(7) != 0) xs.sort();
    write_reg(REG_ENABLED, $urandom_range(9) != 0);
    write_reg(REG_VERTEX_COUNT, n);
    for (int i = 0; i < n; i++) load_vertex(i, xs[i], rnd24());
    nq = $urandom_range(5, 30);
    for (int i = 0; i < nq; i++) begin
      k = $urandom_range(n - 1);
      case ($urandom_range(4))
        0: query_at(xs[k]);
        1: query_at(clip24(longint'(xs[k]) + $signed($urandom_range(64)) - 32));
        2: query_at($urandom_range(1) ? 8388607 - $urandom_range(255)
                                      : -8388608 + $urandom_range(255));
        default: query_at(rnd24());
      endcase
      if ($urandom_range(9) == 0) load_vertex($urandom_range(n, 1023), rnd24(), rnd24());
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_seq++;
    repeat (10) query_at(rnd24());
    wait_drained();
  endtask

  task automatic test_random_terrain();
    while (items_sent < TARGET_ITEMS / 3) random_phase();
    no_idle = 1'b1;
    repeat (4) random_phase();
    no_idle = 1'b0;
    test_backpressure();
    while (items_sent < TARGET_ITEMS) random_phase();
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_chan.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= no_idle || ($urandom_range(99) >= 22);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: height=%0d", out_chan.height);
        failures++;
      end else begin
        got = pending_results.pop_front();
        if (out_chan.height !== got.height) begin
          $error("height: expected %0d, got %0d", got.height, out_chan.height);
          failures++;
        end
        if (out_chan.slope !== got.slope) begin
          $error("slope: expected %0d, got %0d", got.slope, out_chan.slope);
          failures++;
        end
        if (out_chan.tangent_x !== got.tangent_x) begin
          $error("tangent_x: expected %0d, got %0d", got.tangent_x, out_chan.tangent_x);
          failures++;
        end
        if (out_chan.tangent_y !== got.tangent_y) begin
          $error("tangent_y: expected %0d, got %0d", got.tangent_y, out_chan.tangent_y);
          failures++;
        end
        if (out_chan.normal_x !== got.normal_x) begin
          $error("normal_x: expected %0d, got %0d", got.normal_x, out_chan.normal_x);
          failures++;
        end
        if (out_chan.normal_y !== got.normal_y) begin
          $error("normal_y: expected %0d, got %0d", got.normal_y, out_chan.normal_y);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)
        || (cfg_chan.valid && cfg_chan.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.mode <= MODE_LOAD;
    in_chan.vertex_index <= '0;
    in_chan.vertex_x <= '0;
    in_chan.vertex_y <= '0;
    in_chan.query_x <= '0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.index <= REG_ENABLED;
    cfg_chan.data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_flat_results();
    test_directed_segments();
    test_full_table();
    test_random_terrain();
    wait_drained();
    repeat (300) @(posedge clk);
    $display("Covered %0d transactions: %0d vertex loads, %0d queries, %0d random phases.",
             items_sent, loads_sent, queries_sent, phases_run);
    $display("Checked %0d results against the predicted terrain samples.", results_seen);
    if (failures == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
src/ptq_pkg.sv
src/ptq_if.sv
src/ptq_div.sv
src/piecewise_linear_terrain_query_unit.sv
tb/piecewise_linear_terrain_query_unit_tb.sv
